[hw/rtl/cll_pkg.sv]
// shared types and codes for the cursor linked list engine
`default_nettype none
package cll_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_FIND   = 2'd1,
    ACT_DELETE = 2'd2
  } action_e;

  typedef struct packed {
    logic [1:0]          action;
    logic signed [31:0]  item_value;
  } in_word_t;

  typedef struct packed {
    logic       status;
    logic [5:0] slot;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic set_full;
    logic start_ins;
    logic start_walk;
    logic walk_step;
    logic hit;
    logic ins_commit;
    logic del_unlink;
    logic del_free;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic free_empty;
    logic walk_end;
    logic walk_hit;
  } stat_t;

endpackage
`default_nettype wire

[hw/rtl/cll_ram.sv]
// generic single write port ram with registered read
`default_nettype none
module cll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[hw/rtl/cll_ctrl.sv]
// sequencer for clear, insert, walk and delete
`default_nettype none
module cll_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [1:0]     in_action,
  output logic                out_valid,
  input  wire logic           out_ready,
  output cll_pkg::cmd_t       cmd,
  input  wire cll_pkg::stat_t stat
);
  import cll_pkg::*;

  typedef enum logic [6:0] {
    S_CLR      = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_INS      = 7'b0000100,
    S_WALK     = 7'b0001000,
    S_DEL_LINK = 7'b0010000,
    S_DEL_FREE = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   is_del_r, is_del_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    is_del_nxt    = is_del_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (in_action)
            ACT_INSERT: begin
              if (stat.free_empty) begin
                cmd.set_full = 1'b1;
                state_nxt    = S_DONE;
              end else begin
                cmd.start_ins = 1'b1;
                state_nxt     = S_INS;
              end
            end
            ACT_FIND: begin
              cmd.start_walk = 1'b1;
              is_del_nxt     = 1'b0;
              state_nxt      = S_WALK;
            end
            ACT_DELETE: begin
              cmd.start_walk = 1'b1;
              is_del_nxt     = 1'b1;
              state_nxt      = S_WALK;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_INS: begin
        cmd.ins_commit = 1'b1;
        state_nxt      = S_DONE;
      end
      S_WALK: begin
        if (stat.walk_end) begin
          state_nxt = S_DONE;
        end else if (stat.walk_hit) begin
          cmd.hit   = 1'b1;
          state_nxt = is_del_r ? S_DEL_LINK : S_DONE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_DEL_LINK: begin
        cmd.del_unlink = 1'b1;
        state_nxt      = S_DEL_FREE;
      end
      S_DEL_FREE: begin
        cmd.del_free = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      is_del_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      is_del_r    <= is_del_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result overwritten while held");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("accepted word did not start work");

  a_step_not_past_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_step |-> !stat.walk_end)
    else $error("walk stepped past end of list");
`endif

endmodule
`default_nettype wire

[hw/rtl/cll_dp.sv]
// heads, walk registers and list stores
`default_nettype none
module cll_dp #(
  parameter int LIST_SIZE = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cll_pkg::cmd_t      cmd,
  output cll_pkg::stat_t          stat,
  input  wire logic signed [31:0] in_value,
  output cll_pkg::out_word_t      out_data
);
  import cll_pkg::*;

  localparam int IW = $clog2(LIST_SIZE);
  typedef logic [IW-1:0] idx_t;
  localparam logic [IW:0] SIZE_W = (IW+1)'(LIST_SIZE);
  localparam idx_t        LAST   = IW'(LIST_SIZE - 1);

  // out-of-range links read as end of list
  function automatic idx_t slot_ok(input idx_t s);
    slot_ok = ({1'b0, s} < SIZE_W) ? s : '0;
  endfunction

  idx_t       clr_idx_r, clr_idx_nxt;
  idx_t       used_head_r, used_head_nxt;
  idx_t       free_head_r, free_head_nxt;
  idx_t       pos_r, pos_nxt;
  idx_t       prev_r, prev_nxt;
  idx_t       succ_r, succ_nxt;
  idx_t       rslot_r, rslot_nxt;
  logic       rstat_r, rstat_nxt;
  logic [31:0] value_r, value_nxt;
  out_word_t  out_r, out_nxt;
  logic [IW+5:0] slot_ext;

  logic       lnk_we;
  idx_t       lnk_wa, lnk_wd, lnk_q, rd_addr;
  logic [31:0] val_q;

  assign slot_ext = {6'b0, rslot_r};

  always_comb begin
    clr_idx_nxt   = clr_idx_r;
    used_head_nxt = used_head_r;
    free_head_nxt = free_head_r;
    pos_nxt       = pos_r;
    prev_nxt      = prev_r;
    succ_nxt      = succ_r;
    rslot_nxt     = rslot_r;
    rstat_nxt     = rstat_r;
    value_nxt     = value_r;
    out_nxt       = out_r;
    lnk_we        = 1'b0;
    lnk_wa        = pos_r;
    lnk_wd        = free_head_r;
    rd_addr       = pos_r;
    if (cmd.clr_wr) begin
      lnk_we      = 1'b1;
      lnk_wa      = clr_idx_r;
      lnk_wd      = (clr_idx_r == LAST) ? '0 : clr_idx_r + idx_t'(1);
      clr_idx_nxt = clr_idx_r + idx_t'(1);
    end
    if (cmd.accept) begin
      value_nxt = in_value;
      rstat_nxt = 1'b0;
      rslot_nxt = '0;
    end
    if (cmd.set_full) begin
      rstat_nxt = 1'b1;
    end
    if (cmd.start_ins) begin
      rd_addr = free_head_r;
      pos_nxt = free_head_r;
    end
    if (cmd.start_walk) begin
      rd_addr  = used_head_r;
      pos_nxt  = used_head_r;
      prev_nxt = '0;
    end
    if (cmd.walk_step) begin
      prev_nxt = pos_r;
      pos_nxt  = slot_ok(lnk_q);
      rd_addr  = slot_ok(lnk_q);
    end
    if (cmd.hit) begin
      rslot_nxt = pos_r;
      succ_nxt  = lnk_q;
    end
    if (cmd.ins_commit) begin
      lnk_we        = 1'b1;
      lnk_wa        = pos_r;
      lnk_wd        = used_head_r;
      free_head_nxt = slot_ok(lnk_q);
      used_head_nxt = pos_r;
      rslot_nxt     = pos_r;
    end
    if (cmd.del_unlink) begin
      if (prev_r == '0) begin
        used_head_nxt = slot_ok(succ_r);
      end else begin
        lnk_we = 1'b1;
        lnk_wa = prev_r;
        lnk_wd = succ_r;
      end
    end
    if (cmd.del_free) begin
      lnk_we        = 1'b1;
      lnk_wa        = pos_r;
      lnk_wd        = free_head_r;
      free_head_nxt = pos_r;
    end
    if (cmd.load_out) begin
      out_nxt.status = rstat_r;
      out_nxt.slot   = slot_ext[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      used_head_r <= '0;
      free_head_r <= idx_t'(1);
    end else begin
      clr_idx_r   <= clr_idx_nxt;
      used_head_r <= used_head_nxt;
      free_head_r <= free_head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    prev_r  <= prev_nxt;
    succ_r  <= succ_nxt;
    rslot_r <= rslot_nxt;
    rstat_r <= rstat_nxt;
    value_r <= value_nxt;
    out_r   <= out_nxt;
  end

  cll_ram #(.WIDTH(IW), .DEPTH(LIST_SIZE)) u_link_ram (
    .clk     (clk),
    .wr_en   (lnk_we),
    .wr_addr (lnk_wa),
    .wr_data (lnk_wd),
    .rd_addr (rd_addr),
    .rd_data (lnk_q)
  );

  cll_ram #(.WIDTH(32), .DEPTH(LIST_SIZE)) u_value_ram (
    .clk     (clk),
    .wr_en   (cmd.ins_commit),
    .wr_addr (pos_r),
    .wr_data (value_r),
    .rd_addr (rd_addr),
    .rd_data (val_q)
  );

  assign stat.clr_last   = (clr_idx_r == LAST);
  assign stat.free_empty = (free_head_r == '0);
  assign stat.walk_end   = (pos_r == '0);
  assign stat.walk_hit   = (val_q == value_r);

  assign out_data = out_r;

endmodule
`default_nettype wire

[hw/rtl/cursor_linked_list_engine.sv]
// one word at a time, one linked slot read per cycle during a walk
// reset: synchronous active-low rst_n, then a clearing pass
//   writes the initial free chain into the link ram; in_ready stays low meanwhile
// a finished result sits in an output register so the next word can be taken
`default_nettype none
module cursor_linked_list_engine #(
  parameter int LIST_SIZE = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // command words
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire cll_pkg::in_word_t   in_data,
  // result words
  output logic                     out_valid,
  input  wire logic                out_ready,
  output cll_pkg::out_word_t       out_data
);
  import cll_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: clearing pass, dispatch on action, walk loop, unlink steps
  cll_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_data.action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // list heads, walk cursor and the two slot stores
  cll_dp #(.LIST_SIZE(LIST_SIZE)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_value (in_data.item_value),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

[tb/cll_list_checker.sv]
// checker for the cursor linked list engine: predicts each result word and compares
module cll_list_checker #(
  parameter int LIST_SIZE = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  cll_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  cll_pkg::out_word_t out_data,
  output int                 fail_count,
  output int                 pending
);
  import cll_pkg::*;

  localparam int PRINT_LIMIT = 40;

  logic [31:0] value_mem [LIST_SIZE];
  logic [5:0]  link_mem  [LIST_SIZE];
  logic [5:0]  used_head;
  logic [5:0]  free_head;
  out_word_t   expected_words [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_LIMIT) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    fail_count++;
  endtask

  // first slot on the used chain holding v, with its predecessor (0 at the head)
  function automatic logic [5:0] find_slot(input logic [31:0] v, output logic [5:0] prev_slot);
    logic [5:0] pos;
    logic [5:0] back;
    pos = used_head;
    back = '0;
    prev_slot = '0;
    for (int n = 0; n < LIST_SIZE && pos != 0; n++) begin
      if (value_mem[pos] == v) begin
        prev_slot = back;
        return pos;
      end
      back = pos;
      pos = link_mem[pos];
    end
    return '0;
  endfunction

  // apply one command word to the predicted list and give its result word
  function automatic out_word_t list_update(input in_word_t w);
    out_word_t  res;
    logic [5:0] pos;
    logic [5:0] prev_slot;
    res = '0;
    case (w.action)
      ACT_INSERT: begin
        if (free_head == 0) begin
          res.status = 1'b1;
        end else begin
          pos = free_head;
          free_head = link_mem[pos];
          value_mem[pos] = w.item_value;
          link_mem[pos] = used_head;
          used_head = pos;
          res.slot = pos;
        end
      end
      ACT_FIND: begin
        res.slot = find_slot(w.item_value, prev_slot);
      end
      ACT_DELETE: begin
        pos = find_slot(w.item_value, prev_slot);
        if (pos != 0) begin
          if (prev_slot == 0) begin
            used_head = link_mem[pos];
          end else begin
            link_mem[prev_slot] = link_mem[pos];
          end
          link_mem[pos] = free_head;
          free_head = pos;
          res.slot = pos;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < LIST_SIZE; i++) begin
        value_mem[i] = '0;
        link_mem[i] = (i + 1 < LIST_SIZE) ? 6'(i + 1) : 6'd0;
      end
      used_head = '0;
      free_head = 6'd1;
      expected_words.delete();
    end else begin
      if (in_valid && in_ready) begin
        expected_words.push_back(list_update(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("result word status %0d slot %0d with none expected",
                                    out_data.status, out_data.slot));
        end else begin
          want = expected_words.pop_front();
          if (out_data.status !== want.status) begin
            report_mismatch($sformatf("status %0d, want %0d", out_data.status, want.status));
          end
          if (out_data.slot !== want.slot) begin
            report_mismatch($sformatf("slot %0d, want %0d", out_data.slot, want.slot));
          end
        end
      end
    end
    pending <= expected_words.size();
  end

endmodule

[tb/tb_top.sv]
// top of the cursor linked list engine testbench: stimulus, receiver pacing and verdict
module tb_top;
  import cll_pkg::*;

  localparam int LIST_SIZE = 64;
  // action code 3 is not an operation, the engine must answer it with an empty result
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1680;
  // longest legal quiet stretch is the pressure hold plus one walk, far below this
  localparam int IDLE_LIMIT = 4000;
  localparam int PRESSURE_AFTER = 500;
  localparam int PRESSURE_HOLD = 400;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  int fail_count;
  int pending;
  int results_seen = 0;
  int idle_cycles = 0;
  int nogap_left = 0;
  // values recently inserted, reused so that finds and deletes mostly hit
  logic [31:0] recent_vals [$];

  always #10 clk = ~clk;

  cursor_linked_list_engine #(.LIST_SIZE(LIST_SIZE)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  cll_list_checker #(.LIST_SIZE(LIST_SIZE)) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // value mix: a tiny set for duplicates, recent inserts for hits, full random for bit coverage
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      return 32'($urandom_range(0, 7));
    end
    if (r < 75 && recent_vals.size() > 0) begin
      return recent_vals[$urandom_range(0, recent_vals.size() - 1)];
    end
    return $urandom();
  endfunction

  // offer one command word, hold it until taken, then maybe leave a gap
  task automatic send_word(input logic [1:0] act, input logic [31:0] val);
    int r;
    int gap;
    in_data <= '{action: act, item_value: val};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (act == ACT_INSERT) begin
      recent_vals.push_back(val);
      if (recent_vals.size() > LIST_SIZE) begin
        void'(recent_vals.pop_front());
      end
    end
    gap = 0;
    if (nogap_left > 0) begin
      // back-to-back stretch
      nogap_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        nogap_left = $urandom_range(20, 60);
      end else if (r < 40) begin
        gap = $urandom_range(1, 3);
      end else if (r < 47) begin
        gap = $urandom_range(4, 10);
      end else if (r < 50) begin
        gap = $urandom_range(20, 80);
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // count delivered result words, used to time the long receiver hold
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      results_seen <= results_seen + 1;
    end
  end

  // watchdog: no word moving on either side for too long means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("cursor_linked_list_engine test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver pacing: short ready bursts and stalls, rare long ones, one forced long hold
  initial begin : receiver
    int  r;
    int  ready_left;
    int  hold_left;
    bit  pressed;
    ready_left = 0;
    hold_left = 0;
    pressed = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (ready_left > 0) begin
        out_ready <= 1'b1;
        ready_left--;
      end else if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!pressed && results_seen >= PRESSURE_AFTER) begin
        // long hold while the sender keeps offering, so the engine backs up
        pressed = 1'b1;
        hold_left = PRESSURE_HOLD;
        out_ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          ready_left = $urandom_range(0, 8);
          out_ready <= 1'b1;
        end else if (r < 93) begin
          hold_left = $urandom_range(0, 2);
          out_ready <= 1'b0;
        end else if (r < 97) begin
          ready_left = $urandom_range(100, 300);
          out_ready <= 1'b1;
        end else begin
          hold_left = $urandom_range(20, 120);
          out_ready <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    int         r;
    int         phase_left;
    bit         filling;
    logic [1:0] act;
    phase_left = 0;
    filling = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extreme values into fresh slots
    send_word(ACT_INSERT, 32'h8000_0000);
    send_word(ACT_INSERT, 32'h7FFF_FFFF);
    send_word(ACT_INSERT, 32'h0000_0000);
    send_word(ACT_INSERT, 32'hFFFF_FFFF);
    send_word(ACT_INSERT, 32'h5555_5555);
    send_word(ACT_INSERT, 32'hAAAA_AAAA);
    // lookups at the tail, next to the head and at the head, then a miss
    send_word(ACT_FIND, 32'h8000_0000);
    send_word(ACT_FIND, 32'h5555_5555);
    send_word(ACT_FIND, 32'hAAAA_AAAA);
    send_word(ACT_FIND, 32'h0001_2345);
    // duplicate value: the newest copy must win for find and delete
    send_word(ACT_INSERT, 32'h7FFF_FFFF);
    send_word(ACT_FIND, 32'h7FFF_FFFF);
    send_word(ACT_DELETE, 32'h7FFF_FFFF);
    send_word(ACT_FIND, 32'h7FFF_FFFF);
    // unlink at the head, the middle and the tail, then a delete that misses
    send_word(ACT_DELETE, 32'hAAAA_AAAA);
    send_word(ACT_DELETE, 32'h0000_0000);
    send_word(ACT_DELETE, 32'h8000_0000);
    send_word(ACT_DELETE, 32'h0001_2345);
    // unused action code leaves the list alone
    send_word(ACT_UNUSED, 32'h5555_5555);
    send_word(ACT_FIND, 32'h5555_5555);
    // freed slots come back from the free chain
    send_word(ACT_INSERT, 32'h1234_5678);
    send_word(ACT_FIND, 32'h1234_5678);

    // random: alternate filling phases (reach full) and draining phases (empty out)
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (phase_left == 0) begin
        filling = !filling;
        phase_left = $urandom_range(80, 250);
      end
      phase_left--;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        act = ACT_UNUSED;
      end else if (filling) begin
        act = (r < 72) ? ACT_INSERT : (r < 86) ? ACT_FIND : ACT_DELETE;
      end else begin
        act = (r < 13) ? ACT_INSERT : (r < 40) ? ACT_FIND : ACT_DELETE;
      end
      send_word(act, pick_value());
    end
    in_valid <= 1'b0;

    // drain: let the count see the last word, wait for every expected result word,
    // then a walk's worth of quiet
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LIST_SIZE + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("cursor_linked_list_engine test passed");
    end else begin
      $display("cursor_linked_list_engine test failed");
    end
    $finish;
  end

endmodule

[cursor_linked_list_engine.f]
hw/rtl/cll_pkg.sv
hw/rtl/cll_ram.sv
hw/rtl/cll_ctrl.sv
hw/rtl/cll_dp.sv
hw/rtl/cursor_linked_list_engine.sv
tb/cll_list_checker.sv
tb/tb_top.sv
